### rtl/ssp_pkg.sv
package ssp_pkg;

    // Largest parameter count that the receiver buffers and sends on.
    localparam int MAX_PARAMS = 16;
    localparam int PB_AW      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int NP_W       = $clog2(MAX_PARAMS + 1);

    // Depth of the queue that separates the parser from the result sender.
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    localparam int APB_AW = 3;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] MIN_LEN   = 8'd2;

    localparam logic [0:0] REG_EXPECTED_ID = 1'b0;
    localparam logic [0:0] REG_TIMEOUT     = 1'b1;

    localparam logic [7:0]  RST_EXPECTED_ID = 8'd1;
    localparam logic [15:0] RST_TIMEOUT     = 16'd50;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_BYTE  = 2'd1,
        FN_TICK  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SERVO_ERR = 3'd1,
        ST_BAD       = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    // One finished packet or event, as handed from the parser to the sender.
    typedef struct packed {
        t_status         status;
        logic [7:0]      servo_error;
        logic [NP_W-1:0] nparams;
    } t_job;

    typedef struct packed {
        logic             we;
        logic [PB_AW-1:0] addr;
        logic [7:0]       data;
    } t_ram_wr;

endpackage

### rtl/ssp_if.sv
interface ssp_in_if;
    import ssp_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface ssp_out_if;
    import ssp_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       has_param;
    logic [7:0] param_byte;
    logic [7:0] servo_error;
    logic       last;

    modport source (output valid, output status, output has_param, output param_byte,
                    output servo_error, output last, input ready);
    modport sink   (input valid, input status, input has_param, input param_byte,
                    input servo_error, input last, output ready);
endinterface

### rtl/ssp_ram.sv
module ssp_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ssp_fifo.sv
module ssp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssp_pkg::t_job i_data,
    input  logic          i_pop,
    output ssp_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    import ssp_pkg::*;

    t_job             r_mem [Q_DEPTH];
    logic [QP_W-1:0]  r_wp;
    logic [QP_W-1:0]  r_rp;
    logic [QC_W-1:0]  r_cnt;

    function automatic logic [QP_W-1:0] f_next(input logic [QP_W-1:0] p);
        f_next = (p == QP_W'(Q_DEPTH - 1)) ? '0 : p + QP_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= f_next(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_next(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == QC_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

### rtl/ssp_front.sv
module ssp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ssp_in_if.sink           i_in,
    input  logic [7:0]       i_expected_id,
    input  logic [15:0]      i_timeout_ticks,
    input  logic             i_q_full,
    input  logic             i_buf_busy,
    output logic             o_push,
    output ssp_pkg::t_job    o_job,
    output ssp_pkg::t_ram_wr o_wr
);
    import ssp_pkg::*;

    typedef enum logic [2:0] {
        PH_DONE, PH_SYNC0, PH_SYNC1, PH_ID, PH_LEN, PH_BODY, PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_err, n_err;
    logic [15:0] r_tick, n_tick;

    logic        accept;
    logic [7:0]  rx;
    logic [7:0]  cnt_inc;
    logic [7:0]  sum_add;
    logic [7:0]  param_idx;
    logic [7:0]  nparams;
    logic [15:0] tick_inc;

    // A body byte may land in the parameter buffer, so it waits until the
    // previous run has been sent completely.
    assign i_in.ready = !i_q_full && !((r_phase == PH_BODY) && i_buf_busy);
    assign accept     = i_in.valid && i_in.ready;
    assign rx         = i_in.rx_byte;

    always_comb begin
        n_phase   = r_phase;
        n_id      = r_id;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_err     = r_err;
        n_tick    = r_tick;
        o_push    = 1'b0;
        o_job     = '{status: ST_OK, servo_error: 8'd0, nparams: '0};
        o_wr      = '{we: 1'b0, addr: '0, data: rx};
        cnt_inc   = r_cnt + 8'd1;
        sum_add   = r_sum + rx;
        param_idx = r_cnt - 8'd1;
        nparams   = r_len - MIN_LEN;
        tick_inc  = (r_tick != 16'hFFFF) ? r_tick + 16'd1 : r_tick;

        if (accept) begin
            unique case (i_in.func)
                FN_START: begin
                    n_phase = PH_SYNC0;
                    n_id    = '0;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_sum   = '0;
                    n_err   = '0;
                    n_tick  = '0;
                end
                FN_TICK: begin
                    if (r_phase != PH_DONE) begin
                        n_tick = tick_inc;
                        if (tick_inc >= i_timeout_ticks) begin
                            n_phase      = PH_DONE;
                            o_push       = 1'b1;
                            o_job.status = ST_TIMEOUT;
                        end
                    end
                end
                FN_BYTE: begin
                    unique case (r_phase)
                        PH_DONE: ;
                        PH_SYNC0: begin
                            if (rx == SYNC_BYTE) begin
                                n_phase = PH_SYNC1;
                            end
                        end
                        PH_SYNC1: begin
                            n_phase = (rx == SYNC_BYTE) ? PH_ID : PH_SYNC0;
                        end
                        PH_ID: begin
                            n_id    = rx;
                            n_sum   = rx;
                            n_phase = PH_LEN;
                        end
                        PH_LEN: begin
                            n_len = rx;
                            n_cnt = '0;
                            if (r_id != i_expected_id) begin
                                n_phase = (rx == 8'd0) ? PH_SYNC0 : PH_SKIP;
                            end else if (rx < MIN_LEN) begin
                                n_phase      = PH_DONE;
                                o_push       = 1'b1;
                                o_job.status = ST_BAD;
                            end else begin
                                n_sum   = sum_add;
                                n_phase = PH_BODY;
                            end
                        end
                        PH_SKIP: begin
                            n_cnt = cnt_inc;
                            if (cnt_inc >= r_len) begin
                                n_phase = PH_SYNC0;
                            end
                        end
                        PH_BODY: begin
                            n_sum = sum_add;
                            n_cnt = cnt_inc;
                            if (r_cnt == 8'd0) begin
                                n_err = rx;
                            end else if (cnt_inc < r_len && param_idx < 8'(MAX_PARAMS)) begin
                                o_wr.we   = 1'b1;
                                o_wr.addr = param_idx[PB_AW-1:0];
                            end
                            if (cnt_inc >= r_len) begin
                                // Checksum byte: the checksum is judged before the length.
                                n_phase = PH_DONE;
                                o_push  = 1'b1;
                                if (sum_add != SYNC_BYTE) begin
                                    o_job.status = ST_BAD;
                                end else if (nparams > 8'(MAX_PARAMS)) begin
                                    o_job.status      = ST_TOO_LONG;
                                    o_job.servo_error = r_err;
                                end else begin
                                    o_job.status      = (r_err != 8'd0) ? ST_SERVO_ERR : ST_OK;
                                    o_job.servo_error = r_err;
                                    o_job.nparams     = nparams[NP_W-1:0];
                                end
                            end
                        end
                        default: n_phase = PH_DONE;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_id    <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_err   <= '0;
            r_tick  <= '0;
        end else begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_err   <= n_err;
            r_tick  <= n_tick;
        end
    end

endmodule

### rtl/ssp_back.sv
module ssp_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  ssp_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic [ssp_pkg::PB_AW-1:0] o_raddr,
    input  logic [7:0]                i_rdata,
    output logic                      o_busy,
    ssp_out_if.source                 o_out
);
    import ssp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE, S_READ, S_LOAD, S_EMIT
    } t_state;

    t_state           r_state;
    t_job             r_job;
    logic [PB_AW-1:0] r_idx;
    logic             r_valid;
    t_status          r_status;
    logic             r_has;
    logic [7:0]       r_param;
    logic [7:0]       r_serr;
    logic             r_last;
    logic             is_last;

    assign o_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign o_raddr = r_idx;
    assign o_busy  = (r_state != S_IDLE);
    assign is_last = ((NP_W'(r_idx) + NP_W'(1)) == r_job.nparams);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_job <= i_job;
                        r_idx <= '0;
                        if (i_job.nparams == '0) begin
                            r_valid  <= 1'b1;
                            r_status <= i_job.status;
                            r_has    <= 1'b0;
                            r_param  <= 8'd0;
                            r_serr   <= i_job.servo_error;
                            r_last   <= 1'b1;
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_LOAD;
                S_LOAD: begin
                    r_valid  <= 1'b1;
                    r_status <= r_job.status;
                    r_has    <= 1'b1;
                    r_param  <= i_rdata;
                    r_serr   <= r_job.servo_error;
                    r_last   <= is_last;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + PB_AW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_status;
    assign o_out.has_param   = r_has;
    assign o_out.param_byte  = r_param;
    assign o_out.servo_error = r_serr;
    assign o_out.last        = r_last;

endmodule

### rtl/servo_status_packet_receiver.sv
// Channel   Dir  Handshake        Payload
// i_in      in   valid / ready    func[1:0], rx_byte[7:0]
// o_out     out  valid / ready    status[2:0], has_param, param_byte[7:0],
//                                 servo_error[7:0], last
// APB       in   psel / penable   paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// The parser takes one input item per cycle; any item waits while the queue
// is full, and during a packet body any item also waits while the previous run
// is still being sent, because a body byte shares the buffer.
// In the sender, the first result of a run takes its job from the queue; each
// result with a parameter then passes buffer read, load and present, held in
// present by any stall on o_out, and a result without one goes straight to present.
// Reset is synchronous and active low; the buffer has no clearing pass.
// A two-entry queue lets the parser run on while the sender is stalled.
module servo_status_packet_receiver (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ssp_in_if.sink                       i_in,
    ssp_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssp_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ssp_pkg::*;

    logic [7:0]       r_expected_id;
    logic [15:0]      r_timeout_ticks;
    logic             cfg_wr;

    logic             push;
    t_job             push_job;
    t_ram_wr          ram_wr;
    logic             q_full;
    logic             q_empty;
    t_job             q_job;
    logic             pop;
    logic             back_busy;
    logic             buf_busy;
    logic [PB_AW-1:0] raddr;
    logic [7:0]       rdata;

    // Configuration registers: two 32-bit slots, written on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id   <= RST_EXPECTED_ID;
            r_timeout_ticks <= RST_TIMEOUT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_EXPECTED_ID: r_expected_id   <= pwdata[7:0];
                REG_TIMEOUT:     r_timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_EXPECTED_ID: prdata = {24'd0, r_expected_id};
            REG_TIMEOUT:     prdata = {16'd0, r_timeout_ticks};
            default:         prdata = 32'd0;
        endcase
    end

    // The parameter buffer is in use while a job waits or is being sent.
    assign buf_busy = back_busy || !q_empty;

    ssp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_expected_id   (r_expected_id),
        .i_timeout_ticks (r_timeout_ticks),
        .i_q_full        (q_full),
        .i_buf_busy      (buf_busy),
        .o_push          (push),
        .o_job           (push_job),
        .o_wr            (ram_wr)
    );

    ssp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PARAMS)
    ) u_param_buf (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ssp_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ssp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (q_job),
        .o_pop     (pop),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_busy    (back_busy),
        .o_out     (o_out)
    );

    // The parser must never overwrite parameters of a run not yet sent.
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr.we |-> !buf_busy)
        else $error("parameter buffer written while a run is pending");

    // A finished packet is never offered to a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("job pushed into a full queue");

    // Taking a job always starts the sender.
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> back_busy)
        else $error("sender stayed idle after taking a job");

endmodule
